FILE: rtl/wcls_pkg.sv
// Package for the word count and line substring match block.
// Holds the result entry type, register indexes, report kinds and the delimiter test.
// No dependencies.
package wcls_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEFAULT_MAX_PATTERN_BYTES = 16;
   localparam int DEFAULT_COUNT_WIDTH       = 32;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PATTERN_FIRST  = 2'd0;
   localparam logic [1:0] CSR_PATTERN_LAST   = 2'd1;
   localparam logic [1:0] CSR_PATTERN_LENGTH = 2'd2;

   // Report kinds.
   localparam logic REPORT_LINE  = 1'b0;
   localparam logic REPORT_COUNT = 1'b1;

   // Token length saturates here.
   localparam logic [4:0] TOKEN_LEN_MAX = 5'd31;

   // Characters that split tokens.
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_APOS     = 8'h27;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_BANG     = 8'h21;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;

   // One result as it waits in the output slots.
   typedef struct packed {
      logic        kind;
      logic [31:0] line;
      logic [31:0] count;
      logic        last;
   } rsp_entry_type;

   // True for every byte that ends a token.
   function automatic logic is_delimiter(input logic [7:0] b);
      logic d;
      case (b) inside
         CH_SPACE, CH_DOT, CH_COMMA, CH_APOS, CH_QUOTE,
         CH_COLON, CH_SEMI, CH_QUESTION, CH_BANG, CH_NEWLINE: d = 1'b1;
         default: d = 1'b0;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/word_count_and_line_substring_match.sv
// A byte taken on req is held in the input stage; its results are registered into the output slots.
// Throughput: one byte per cycle while its results fit; results leave one per cycle while
// rsp_ready is high, in order from two output slots; a byte whose results do not fit stalls.
// Reset (synchronous, active high) restores the pattern registers to their reset values,
// empties the input stage and output slots and starts a new file at line 1.
// Depends on wcls_pkg.
module word_count_and_line_substring_match
   import wcls_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES,
   parameter int COUNT_WIDTH       = DEFAULT_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   // Byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   // Results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_report_kind,
   output logic [31:0] rsp_line_number,
   output logic [31:0] rsp_word_count,
   output logic        rsp_last_of_run,
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int WIN_W = 8 * MAX_PATTERN_BYTES;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Configuration registers and the pattern aligned to the window.
   logic [63:0]        pat_lo_ff, pat_hi_ff;
   logic [4:0]         pat_len_ff;
   logic [LEN_W-1:0]   eff_len;
   logic [127:0]       pat_all;
   logic [LEN_W-1:0]   shift_bytes;
   logic [WIN_W-1:0]   align_ff, align_in;
   logic [MAX_PATTERN_BYTES-1:0] mask_ff, mask_in;

   // Input stage.
   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_eof_ff;

   // File state.
   logic [7:0]         recent_ff [MAX_PATTERN_BYTES];
   logic [LEN_W-1:0]   bil_ff, bil_in;
   logic [4:0]         tl_ff, tl_in;
   logic               teq_ff, teq_in;
   logic               lhp_ff, lhp_in;
   logic [COUNT_WIDTH-1:0] line_ff, line_in;
   logic [COUNT_WIDTH-1:0] words_ff, words_in;

   // Processing signals.
   logic               delim, newline, line_end;
   logic [7:0]         tok_pat;
   logic [4:0]         tl_step;
   logic               teq_step;
   logic [4:0]         tl_done;
   logic               teq_done;
   logic               token_hit;
   logic [COUNT_WIDTH-1:0] words_after;
   logic [LEN_W-1:0]   bil_step;
   logic [WIN_W-1:0]   rev_win;
   logic               win_equal;
   logic               lhp_after;
   logic               has_line;
   logic [1:0]         n_res;
   rsp_entry_type      line_res, count_res, r0, r1;

   // Output slots.
   rsp_entry_type      q0_ff, q1_ff, q0_in, q1_in;
   logic [1:0]         q_count_ff, q_count_in;
   logic [1:0]         keep_cnt;
   logic               pop;
   logic               advance;

   // Configuration write port is always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= 5'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_FIRST:  pat_lo_ff  <= csr_data;
            CSR_PATTERN_LAST:   pat_hi_ff  <= csr_data;
            CSR_PATTERN_LENGTH: pat_len_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Effective length: zero acts as one, anything above the window acts as the window.
   always_comb begin
      if (pat_len_ff == 5'd0) begin
         eff_len = LEN_W'(1);
      end else if (pat_len_ff > 5'(MAX_PATTERN_BYTES)) begin
         eff_len = LEN_MAX;
      end else begin
         eff_len = pat_len_ff[LEN_W-1:0];
      end
   end

   assign pat_all = {pat_hi_ff, pat_lo_ff};

   // Pattern moved to the top of the window, with a mask over the compared bytes.
   // It is registered from the pattern registers every cycle, so it follows a configuration write.
   always_comb begin
      shift_bytes = LEN_MAX - eff_len;
      align_in    = pat_all[WIN_W-1:0] << {shift_bytes, 3'b000};
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         mask_in[k] = (LEN_W'(k) >= shift_bytes);
      end
   end

   always_ff @(posedge clock) begin
      align_ff <= align_in;
      mask_ff  <= mask_in;
   end

   // Output slot bookkeeping and the input stage handshake.
   assign pop       = (q_count_ff != 2'd0) && rsp_ready;
   assign keep_cnt  = q_count_ff - {1'b0, pop};
   assign advance   = s1_valid_ff && ((3'({1'b0, keep_cnt}) + 3'(n_res)) <= 3'd2);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_byte_ff <= req_data_byte;
         s1_eof_ff  <= req_end_of_file;
      end
   end

   // Token tracking: whole-word comparison against the pattern.
   always_comb begin
      delim    = is_delimiter(s1_byte_ff);
      newline  = (s1_byte_ff == CH_NEWLINE);
      line_end = newline || s1_eof_ff;
      tok_pat  = pat_all[{tl_ff[3:0], 3'b000} +: 8];
      teq_step = teq_ff && !((tl_ff >= 5'(eff_len)) || (s1_byte_ff != tok_pat));
      tl_step  = (tl_ff < TOKEN_LEN_MAX) ? tl_ff + 5'd1 : tl_ff;
      // A delimiter closes the old token; end of file closes the one that includes this byte.
      tl_done  = delim ? tl_ff : tl_step;
      teq_done = delim ? teq_ff : teq_step;
      token_hit = (delim || s1_eof_ff) && (tl_done != 5'd0) && teq_done &&
                  (tl_done == 5'(eff_len));
      words_after = (token_hit && (words_ff != COUNT_MAX)) ? words_ff + 1'b1 : words_ff;
   end

   // Substring window: newest byte first, compared oldest first against the pattern.
   always_comb begin
      bil_step = (bil_ff < LEN_MAX) ? bil_ff + 1'b1 : bil_ff;
      for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
         rev_win[8*k +: 8] = recent_ff[MAX_PATTERN_BYTES - 2 - k];
      end
      rev_win[WIN_W-8 +: 8] = s1_byte_ff;
      win_equal = 1'b1;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         if (mask_ff[k] && (rev_win[8*k +: 8] != align_ff[8*k +: 8])) begin
            win_equal = 1'b0;
         end
      end
      lhp_after = lhp_ff || ((bil_step >= eff_len) && win_equal);
      has_line  = line_end && lhp_after;
   end

   // Results caused by this byte.
   always_comb begin
      line_res.kind   = REPORT_LINE;
      line_res.line   = 32'(line_ff);
      line_res.count  = '0;
      line_res.last   = !s1_eof_ff;
      count_res.kind  = REPORT_COUNT;
      count_res.line  = '0;
      count_res.count = 32'(words_after);
      count_res.last  = 1'b1;
      r0    = has_line ? line_res : count_res;
      r1    = count_res;
      n_res = 2'({1'b0, has_line}) + 2'({1'b0, s1_eof_ff});
   end

   // Next file state; end of file returns it all to the start of a new file.
   always_comb begin
      if (s1_eof_ff) begin
         tl_in    = '0;
         teq_in   = 1'b1;
         lhp_in   = 1'b0;
         bil_in   = '0;
         line_in  = COUNT_WIDTH'(1);
         words_in = '0;
      end else begin
         tl_in    = delim ? 5'd0 : tl_step;
         teq_in   = delim ? 1'b1 : teq_step;
         lhp_in   = newline ? 1'b0 : lhp_after;
         bil_in   = newline ? '0 : bil_step;
         line_in  = (newline && (line_ff != COUNT_MAX)) ? line_ff + 1'b1 : line_ff;
         words_in = words_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tl_ff    <= '0;
         teq_ff   <= 1'b1;
         lhp_ff   <= 1'b0;
         bil_ff   <= '0;
         line_ff  <= COUNT_WIDTH'(1);
         words_ff <= '0;
      end else if (advance) begin
         tl_ff    <= tl_in;
         teq_ff   <= teq_in;
         lhp_ff   <= lhp_in;
         bil_ff   <= bil_in;
         line_ff  <= line_in;
         words_ff <= words_in;
      end
   end

   // Window bytes older than the line's byte count are never compared, so they need no clear.
   always_ff @(posedge clock) begin
      if (advance) begin
         recent_ff[0] <= s1_byte_ff;
         for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
            recent_ff[j] <= recent_ff[j-1];
         end
      end
   end

   // Output slots: the head drains first, new results append behind what is kept.
   always_comb begin
      q0_in      = pop ? q1_ff : q0_ff;
      q1_in      = q1_ff;
      q_count_in = keep_cnt;
      if (advance) begin
         q_count_in = keep_cnt + n_res;
         if (keep_cnt == 2'd0) begin
            q0_in = r0;
            q1_in = r1;
         end else if (keep_cnt == 2'd1) begin
            q1_in = r0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= '0;
      end else begin
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_valid       = (q_count_ff != 2'd0);
   assign rsp_report_kind = q0_ff.kind;
   assign rsp_line_number = q0_ff.line;
   assign rsp_word_count  = q0_ff.count;
   assign rsp_last_of_run = q0_ff.last;

`ifndef NO_ASSERTIONS
   // The two output slots are never overfilled.
   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= 2'd2)
      else $error("output slot count above two");

   // A final count is always the last result of its byte.
   a_count_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_report_kind == REPORT_COUNT)) |-> rsp_last_of_run)
      else $error("final count not marked last");

   // End of file restarts the line numbering and the word count.
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_eof_ff) |=> ((line_ff == COUNT_WIDTH'(1)) && (words_ff == '0)))
      else $error("state not cleared after end of file");

   // The input only stalls behind a held byte.
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff)
      else $error("input stalled with empty stage");

   // A processed byte always leaves its results in the slots.
   a_results_land: assert property (@(posedge clock) disable iff (reset)
      (advance && (n_res != 2'd0)) |=> (q_count_ff != 2'd0))
      else $error("results of a byte were lost");
`endif

endmodule
